/* hw/rtl/disk_block_bitmap_allocator_defines.svh */
// Assertion macros for the disk block bitmap allocator.
// Included by the top level; no other dependencies.
`ifndef DISK_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define DISK_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define DBBA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define DBBA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DBBA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define DBBA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/dbba_pkg.sv */
// Package for the disk block bitmap allocator: sizes, codes and payload types.
// No dependencies.
package dbba_pkg;

  localparam int MAX_BLOCKS      = 4096;
  localparam int MAX_PER_REQUEST = 64;
  localparam int WORD_LEN        = 64;                       // bitmap memory row width
  localparam int ROWS            = MAX_BLOCKS / WORD_LEN;
  localparam int ROW_W           = $clog2(ROWS);
  localparam int POS_W           = $clog2(WORD_LEN);
  localparam int BLK_W           = 12;
  localparam int CNT_W           = 13;
  localparam int REQ_CNT_W       = 7;
  localparam int DIV_STEPS       = BLK_W;
  localparam int DIV_STEP_W      = $clog2(DIV_STEPS);

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_GRANT    = 2'd0;
  localparam logic [1:0] ST_REFUSED  = 2'd1;
  localparam logic [1:0] ST_FREED    = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_TOTAL     = 2'd0;
  localparam logic [1:0] REG_WORD_BITS = 2'd1;
  localparam logic [1:0] REG_HEADS     = 2'd2;
  localparam logic [1:0] REG_SECTORS   = 2'd3;

  // Register reset values
  localparam logic [12:0] RST_TOTAL     = 13'd4096;
  localparam logic [6:0]  RST_WORD_BITS = 7'd32;
  localparam logic [7:0]  RST_HEADS     = 8'd16;
  localparam logic [7:0]  RST_SECTORS   = 8'd63;

  typedef struct packed {
    logic        command;
    logic [6:0]  count;
    logic [11:0] block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] block_number;
    logic [6:0]  word_row;
    logic [5:0]  bit_column;
    logic [11:0] cylinder_number;
    logic [7:0]  head_number;
    logic [7:0]  sector_number;
    logic [12:0] free_blocks;
    logic        last;
  } rsp_t;

endpackage

/* hw/rtl/dbba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dbba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/disk_block_bitmap_allocator.sv */
// Disk block bitmap allocator: keeps a used bit per block plus a free count.
// Depends on dbba_pkg, dbba_ram and disk_block_bitmap_allocator_defines.svh.
//
// One request is taken at a time (req_ready is high only while the sequencer
// is idle). An allocate of N blocks scans the bitmap from block 0 upward, one
// 64-bit memory row per visit (each visit is a read, then a search), and for
// every free block found claims it, then runs a shared 12-step restoring
// divider twice (block / sectors, then that quotient / heads) to form the
// sector, head and cylinder. A free reads its row, clears the block's used bit
// and runs the same divider; a refused allocate or a bad free skips the divider
// and goes straight to the output stage with its status. Results leave through an
// output register, so the sequencer only stalls when a new result finds the
// previous one still untaken. The bitmap sits in one RAM of 64 rows with a
// valid flag per row; reset or a write of total_blocks clears the flags at
// once, so there is no clearing pass. Configuration writes are accepted at any
// time (cfg_ready is tied high) but must only be issued while the block is idle.
`include "disk_block_bitmap_allocator_defines.svh"

module disk_block_bitmap_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dbba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output dbba_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_data
);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LOAD    = 3'd1;  // row read returns, latch it
  localparam logic [2:0] S_SCAN    = 3'd2;  // search latched row for a free bit
  localparam logic [2:0] S_DIV     = 3'd3;  // CHS split on the shared divider
  localparam logic [2:0] S_EMIT    = 3'd4;  // hand result to output register
  localparam logic [2:0] S_FREE_LD = 3'd5;  // row read for a free transaction

  localparam int WL = dbba_pkg::WORD_LEN;

  logic [2:0] state;

  // Configuration
  logic [12:0] total;
  logic [6:0]  word_bits;
  logic [7:0]  heads;
  logic [7:0]  sectors;
  logic [12:0] total_eff;
  logic [7:0]  heads_eff;
  logic [7:0]  sectors_eff;
  logic        wide_words;

  // Bitmap and counters
  logic [dbba_pkg::ROWS-1:0]  row_valid;
  logic [dbba_pkg::CNT_W-1:0] free_count;
  logic [dbba_pkg::ROW_W-1:0] row;
  logic [WL-1:0]              word;
  logic [dbba_pkg::REQ_CNT_W-1:0] n_left;

  // Result under construction
  logic [1:0]                 st;
  logic                       addr_ok;
  logic                       last_q;
  logic [dbba_pkg::BLK_W-1:0] blk;
  logic [7:0]                 sect;
  logic [7:0]                 head;
  logic [11:0]                cyl;

  // Shared divider
  logic [dbba_pkg::BLK_W-1:0]      dq;
  logic [7:0]                      rem;
  logic [dbba_pkg::DIV_STEP_W-1:0] div_step;
  logic                            div_phase;
  logic [7:0]                      divisor;
  logic [8:0]                      trial;
  logic                            trial_ge;
  logic [7:0]                      rem_next;
  logic [dbba_pkg::BLK_W-1:0]      dq_next;

  // RAM ports
  logic                       ram_we;
  logic [dbba_pkg::ROW_W-1:0] ram_waddr;
  logic [WL-1:0]              ram_wdata;
  logic [dbba_pkg::ROW_W-1:0] ram_raddr;
  logic [WL-1:0]              ram_rdata;
  logic [WL-1:0]              cur_word;

  // Search
  logic [WL-1:0]              beyond;
  logic [WL-1:0]              search_vec;
  logic                       found;
  logic [dbba_pkg::POS_W-1:0] free_pos;
  logic [WL-1:0]              claimed_word;
  logic [WL-1:0]              freed_word;
  logic                       refuse;
  logic                       req_fire;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;

  assign total_eff   = (total > 13'(dbba_pkg::MAX_BLOCKS)) ? 13'(dbba_pkg::MAX_BLOCKS) : total;
  assign heads_eff   = (heads == 8'd0) ? 8'd1 : heads;
  assign sectors_eff = (sectors == 8'd0) ? 8'd1 : sectors;
  assign wide_words  = (word_bits == 7'd64);

  assign refuse = (req.count == 7'd0)
               || (req.count > 7'(dbba_pkg::MAX_PER_REQUEST))
               || ({6'd0, req.count} > free_count);

  // Rows never written read as all free
  assign cur_word = row_valid[row] ? ram_rdata : '0;

  // Mask blocks at or above the effective total so they are never granted
  always_comb begin
    for (int j = 0; j < WL; j++) begin
      beyond[j] = ({1'b0, row, dbba_pkg::POS_W'(j)} >= total_eff);
    end
  end

  assign search_vec = word | beyond;

  // Lowest clear bit
  always_comb begin
    found    = 1'b0;
    free_pos = '0;
    for (int j = WL - 1; j >= 0; j--) begin
      if (!search_vec[j]) begin
        found    = 1'b1;
        free_pos = dbba_pkg::POS_W'(j);
      end
    end
  end

  assign claimed_word = word | (WL'(1) << free_pos);
  assign freed_word   = cur_word & ~(WL'(1) << blk[dbba_pkg::POS_W-1:0]);

  // One restoring division step per cycle
  assign divisor  = div_phase ? heads_eff : sectors_eff;
  assign trial    = {rem, dq[dbba_pkg::BLK_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor});
  assign rem_next = trial_ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
  assign dq_next  = {dq[dbba_pkg::BLK_W-2:0], trial_ge};

  // RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row;
    ram_wdata = claimed_word;
    ram_raddr = row;
    unique case (state)
      S_IDLE: begin
        ram_raddr = (req.command == dbba_pkg::CMD_FREE)
                  ? req.block_index[dbba_pkg::BLK_W-1:dbba_pkg::POS_W] : '0;
      end
      S_SCAN: begin
        ram_we    = found;
        ram_raddr = row + dbba_pkg::ROW_W'(1);
      end
      S_FREE_LD: begin
        ram_we    = cur_word[blk[dbba_pkg::POS_W-1:0]];
        ram_wdata = freed_word;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  dbba_ram #(
    .WIDTH(WL),
    .DEPTH(dbba_pkg::ROWS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      row_valid  <= '0;
      free_count <= dbba_pkg::RST_TOTAL;
      total      <= dbba_pkg::RST_TOTAL;
      word_bits  <= dbba_pkg::RST_WORD_BITS;
      heads      <= dbba_pkg::RST_HEADS;
      sectors    <= dbba_pkg::RST_SECTORS;
    end else begin
      // Drop valid once the result is taken, unless a new one replaces it
      if (rsp_valid && rsp_ready && (state != S_EMIT)) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          dbba_pkg::REG_TOTAL: begin
            // New disk size: drop the whole map
            total      <= cfg_data;
            row_valid  <= '0;
            free_count <= (cfg_data > 13'(dbba_pkg::MAX_BLOCKS))
                        ? 13'(dbba_pkg::MAX_BLOCKS) : cfg_data;
          end
          dbba_pkg::REG_WORD_BITS: word_bits <= cfg_data[6:0];
          dbba_pkg::REG_HEADS:     heads     <= cfg_data[7:0];
          dbba_pkg::REG_SECTORS:   sectors   <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            blk <= req.block_index;
            if (req.command == dbba_pkg::CMD_FREE) begin
              if ({1'b0, req.block_index} >= total_eff) begin
                st      <= dbba_pkg::ST_BAD_FREE;
                addr_ok <= 1'b0;
                last_q  <= 1'b1;
                state   <= S_EMIT;
              end else begin
                row   <= req.block_index[dbba_pkg::BLK_W-1:dbba_pkg::POS_W];
                state <= S_FREE_LD;
              end
            end else if (refuse) begin
              st      <= dbba_pkg::ST_REFUSED;
              addr_ok <= 1'b0;
              last_q  <= 1'b1;
              state   <= S_EMIT;
            end else begin
              row    <= '0;
              n_left <= req.count;
              state  <= S_LOAD;
            end
          end
        end

        S_LOAD: begin
          word  <= cur_word;
          state <= S_SCAN;
        end

        S_SCAN: begin
          if (found) begin
            // Claim the block and start the CHS split
            word       <= claimed_word;
            blk        <= {row, free_pos};
            free_count <= free_count - dbba_pkg::CNT_W'(1);
            n_left     <= n_left - dbba_pkg::REQ_CNT_W'(1);
            last_q     <= (n_left == dbba_pkg::REQ_CNT_W'(1));
            st         <= dbba_pkg::ST_GRANT;
            addr_ok    <= 1'b1;
            dq         <= {row, free_pos};
            rem        <= '0;
            div_step   <= '0;
            div_phase  <= 1'b0;
            state      <= S_DIV;
          end else begin
            // Advance to the next row; its read is already issued
            row   <= row + dbba_pkg::ROW_W'(1);
            state <= S_LOAD;
          end
        end

        S_FREE_LD: begin
          if (!cur_word[blk[dbba_pkg::POS_W-1:0]]) begin
            st      <= dbba_pkg::ST_BAD_FREE;
            addr_ok <= 1'b0;
            last_q  <= 1'b1;
            state   <= S_EMIT;
          end else begin
            free_count <= free_count + dbba_pkg::CNT_W'(1);
            st         <= dbba_pkg::ST_FREED;
            addr_ok    <= 1'b1;
            last_q     <= 1'b1;
            dq         <= blk;
            rem        <= '0;
            div_step   <= '0;
            div_phase  <= 1'b0;
            state      <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_step == dbba_pkg::DIV_STEP_W'(dbba_pkg::DIV_STEPS - 1)) begin
            div_step <= '0;
            if (!div_phase) begin
              // block / sectors done: remainder is the sector, reuse quotient
              sect      <= rem_next;
              dq        <= dq_next;
              rem       <= '0;
              div_phase <= 1'b1;
            end else begin
              cyl   <= dq_next;
              head  <= rem_next;
              state <= S_EMIT;
            end
          end else begin
            dq       <= dq_next;
            rem      <= rem_next;
            div_step <= div_step + dbba_pkg::DIV_STEP_W'(1);
          end
        end

        S_EMIT: begin
          // Hold until the output register is free
          if (!rsp_valid || rsp_ready) begin
            rsp_valid            <= 1'b1;
            rsp.status           <= st;
            rsp.block_number     <= addr_ok ? blk : '0;
            rsp.word_row         <= !addr_ok ? '0
                                  : wide_words ? 7'(blk >> 6) : 7'(blk >> 5);
            rsp.bit_column       <= !addr_ok ? '0
                                  : wide_words ? blk[5:0] : {1'b0, blk[4:0]};
            rsp.cylinder_number  <= addr_ok ? cyl : '0;
            rsp.head_number      <= addr_ok ? head : '0;
            rsp.sector_number    <= addr_ok ? sect : '0;
            rsp.free_blocks      <= free_count;
            rsp.last             <= last_q;
            state                <= last_q ? S_IDLE : S_SCAN;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // The free count can never exceed the effective total of blocks
  `DBBA_ASSERT_IMP(a_free_le_total, clk, rst, 1'b1, free_count <= total_eff, "free count above total")
  // A granted block always lies inside the disk
  `DBBA_ASSERT_IMP(a_grant_in_range, clk, rst, rsp_valid && (rsp.status == dbba_pkg::ST_GRANT), 13'(rsp.block_number) < total_eff, "granted block out of range")
  // The divider only hands over to the output stage
  `DBBA_ASSERT_NXT(a_div_exit, clk, rst, state == S_DIV, (state == S_DIV) || (state == S_EMIT), "bad exit from divide")

endmodule
